### design/flash_page_write_combiner_core_assert.svh
// Assertion macros used by the checker of the page write combiner.
`ifndef FLASH_PAGE_WRITE_COMBINER_CORE_ASSERT_SVH
`define FLASH_PAGE_WRITE_COMBINER_CORE_ASSERT_SVH

// Checked on every rising edge of clk, switched off while rst is high.
`define FPWC_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, also during reset.
`define FPWC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/fpwc_pkg.sv
// Package of the page write combiner: widths, codes and the shared item types.
package fpwc_pkg;

  localparam int PAGE_BYTES_DEF   = 256;
  localparam int ADDRESS_BITS_DEF = 24;

  localparam int OUT_ADDR_W = 24;
  localparam int WORD_IDX_W = 5;
  localparam int DATA_W     = 64;
  localparam int COUNT_W    = 25;
  localparam int OFFSET_W   = 24;
  localparam int BASE_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 25'h1000000;
  localparam logic [7:0]         BLANK_BYTE = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd1;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_EMIT  = 1'b1
  } cmd_op_t;

  // A store carries the byte address; an emit carries the page address and
  // the byte count to report with the page.
  typedef struct packed {
    cmd_op_t                 op;
    logic [OUT_ADDR_W-1:0]   addr;
    logic [7:0]              data;
    logic [COUNT_W-1:0]      count;
  } cmd_t;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0]   page_address;
    logic [WORD_IDX_W-1:0]   word_index;
    logic [DATA_W-1:0]       word_data;
    logic                    last_word;
    logic [COUNT_W-1:0]      bytes_stored;
  } out_t;

endpackage

### design/fpwc_fifo.sv
// Small register queue used between the front and back parts and at the output.
module fpwc_fifo
  import fpwc_pkg::*;
#(
  parameter int DEPTH = CMD_DEPTH,
  parameter int WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CW'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

### design/fpwc_front.sv
// Front part: takes input items, filters and maps bytes, and decides page emissions.
module fpwc_front
  import fpwc_pkg::*;
#(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  input  logic                   mode,
  input  logic [OFFSET_W-1:0]    byte_offset,
  input  logic [7:0]             data_byte,
  output logic                   full,
  input  logic                   cmd_full,
  output logic                   cmd_push,
  output cmd_t                   cmd
);

  localparam int SUM_W = (ADDRESS_BITS > COUNT_W) ? ADDRESS_BITS : COUNT_W;
  localparam logic [ADDRESS_BITS-1:0] PAGE_MASK = ~ADDRESS_BITS'(PAGE_BYTES - 1);

  logic [BASE_W-1:0]        transfer_base;
  logic [COUNT_W-1:0]       transfer_size;
  logic [ADDRESS_BITS-1:0]  current_page;
  logic                     page_pending;
  logic [COUNT_W-1:0]       stored_count;
  logic                     hold_valid;
  cmd_t                     hold_cmd;

  logic                     accept;
  logic                     in_range;
  logic [SUM_W-1:0]         addr_sum;
  logic [ADDRESS_BITS-1:0]  byte_addr;
  logic [ADDRESS_BITS-1:0]  byte_page;
  logic                     emit_now;
  logic                     store_now;
  cmd_t                     emit_cmd;
  cmd_t                     store_cmd;

  assign full      = hold_valid || cmd_full;
  assign accept    = push && !full;
  assign in_range  = ({1'b0, byte_offset} < transfer_size);
  assign addr_sum  = SUM_W'(transfer_base) + SUM_W'(byte_offset);
  assign byte_addr = addr_sum[ADDRESS_BITS-1:0];
  assign byte_page = byte_addr & PAGE_MASK;
  assign store_now = !mode && in_range;
  assign emit_now  = page_pending && (mode || (in_range && (current_page != byte_page)));

  always_comb begin
    emit_cmd.op     = CMD_EMIT;
    emit_cmd.addr   = OUT_ADDR_W'(current_page);
    emit_cmd.data   = 8'h00;
    emit_cmd.count  = stored_count;
    store_cmd.op    = CMD_STORE;
    store_cmd.addr  = OUT_ADDR_W'(byte_addr);
    store_cmd.data  = data_byte;
    store_cmd.count = stored_count;
  end

  always_comb begin
    if (hold_valid) begin
      cmd_push = !cmd_full;
      cmd      = hold_cmd;
    end else if (accept && emit_now) begin
      cmd_push = 1'b1;
      cmd      = emit_cmd;
    end else begin
      cmd_push = accept && store_now;
      cmd      = store_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_base <= '0;
      transfer_size <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BASE: transfer_base <= cfg_data[BASE_W-1:0];
        CFG_SIZE: transfer_size <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_page <= '0;
      page_pending <= 1'b0;
      stored_count <= '0;
      hold_valid   <= 1'b0;
    end else begin
      if (hold_valid && !cmd_full) begin
        hold_valid <= 1'b0;
      end
      if (accept) begin
        if (emit_now && store_now) begin
          hold_valid <= 1'b1;
        end
        if (store_now) begin
          current_page <= byte_page;
          page_pending <= 1'b1;
          if (stored_count < COUNT_MAX) begin
            stored_count <= stored_count + COUNT_W'(1);
          end
        end else if (emit_now) begin
          page_pending <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit_now && store_now) begin
      hold_cmd <= store_cmd;
    end
  end

endmodule

### design/fpwc_back.sv
// Back part: writes bytes into the page memory and reads pages out word by word.
module fpwc_back
  import fpwc_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_empty,
  input  cmd_t                             cmd,
  output logic                             cmd_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]   oq_count,
  output logic                             oq_push,
  output out_t                             oq_data
);

  localparam int WORDS    = PAGE_BYTES / 8;
  localparam int WORD_AW  = $clog2(WORDS);
  localparam int PAGE_AW  = $clog2(PAGE_BYTES);
  localparam int OQ_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_CMD  = 2'b01,
    ST_EMIT = 2'b10
  } back_state_t;

  back_state_t               state;
  back_state_t               state_next;
  logic [WORD_AW-1:0]        word;
  logic [OUT_ADDR_W-1:0]     emit_page;
  logic [COUNT_W-1:0]        emit_count;
  logic                      rd_pend;
  logic [WORD_AW-1:0]        rd_idx;
  logic [7:0][7:0]           rd_row;
  logic [7:0]                rd_vld;
  logic [PAGE_BYTES-1:0]     byte_valid;
  logic [7:0][7:0]           page_mem [WORDS];

  logic                      credit;
  logic                      issue;
  logic                      last_issue;
  logic                      store_wr;
  logic [PAGE_AW-1:0]        pos;

  assign credit     = ((OQ_CNT_W + 1)'(oq_count) + (OQ_CNT_W + 1)'(rd_pend))
                      < (OQ_CNT_W + 1)'(OUT_DEPTH);
  assign issue      = (state == ST_EMIT) && credit;
  assign last_issue = (word == WORD_AW'(WORDS - 1));
  assign cmd_pop    = (state == ST_CMD) && !cmd_empty;
  assign store_wr   = cmd_pop && (cmd.op == CMD_STORE);
  assign pos        = cmd.addr[PAGE_AW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CMD: begin
        if (cmd_pop && (cmd.op == CMD_EMIT)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (issue && last_issue) begin
          state_next = ST_CMD;
        end
      end
      default: state_next = ST_CMD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CMD;
      word    <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (cmd_pop && (cmd.op == CMD_EMIT)) begin
        word <= '0;
      end else if (issue) begin
        word <= word + WORD_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.op == CMD_EMIT)) begin
      emit_page  <= cmd.addr;
      emit_count <= cmd.count;
    end
    if (issue) begin
      rd_idx <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      page_mem[pos[PAGE_AW-1:3]][pos[2:0]] <= cmd.data;
    end
    if (issue) begin
      rd_row <= page_mem[word];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= '0;
    end else if (issue && last_issue) begin
      byte_valid <= '0;
    end else if (store_wr) begin
      byte_valid[pos] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_vld <= byte_valid[{word, 3'b000} +: 8];
    end
  end

  always_comb begin
    oq_push              = rd_pend;
    oq_data.page_address = emit_page;
    oq_data.word_index   = WORD_IDX_W'(rd_idx);
    oq_data.last_word    = (rd_idx == WORD_AW'(WORDS - 1));
    oq_data.bytes_stored = emit_count;
    for (int lane = 0; lane < 8; lane++) begin
      oq_data.word_data[lane*8 +: 8] = rd_vld[lane] ? rd_row[lane] : BLANK_BYTE;
    end
  end

endmodule

### design/flash_page_write_combiner_core.sv
// Top level of the page write combiner: front part, command queue, back part, output queue.
//
//   channel   handshake               payload
//   input     push / full             mode, byte_offset, data_byte
//   result    empty / pop             page_address, word_index, word_data,
//                                     last_word, bytes_stored
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item is taken per cycle while full is low; an item that closes a dirty page holds
// the input while its store follows the emit into the queue.
// A page goes out as PAGE_BYTES/8 words at one word per cycle while the output queue has
// room, through the single read port of the page memory; stores queued behind it wait.
// Reset is synchronous and clears all control state and the byte valid map.
// Either side may stall on its own; the queues absorb short stalls.
module flash_page_write_combiner_core
  import fpwc_pkg::*;
#(
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic                   mode,
  input  logic [OFFSET_W-1:0]    byte_offset,
  input  logic [7:0]             data_byte,
  output logic                   empty,
  input  logic                   pop,
  output logic [OUT_ADDR_W-1:0]  page_address,
  output logic [WORD_IDX_W-1:0]  word_index,
  output logic [DATA_W-1:0]      word_data,
  output logic                   last_word,
  output logic [COUNT_W-1:0]     bytes_stored
);

  localparam int OQ_CNT_W = $clog2(OUT_DEPTH + 1);

  cmd_t                 front_cmd;
  cmd_t                 back_cmd;
  logic                 cmd_push;
  logic                 cmd_full;
  logic                 cmd_pop;
  logic                 cmd_empty;
  logic                 oq_push;
  out_t                 oq_wdata;
  out_t                 oq_rdata;
  logic [OQ_CNT_W-1:0]  oq_count;

  assign cfg_ready = 1'b1;

  fpwc_front #(
    .PAGE_BYTES   (PAGE_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .mode        (mode),
    .byte_offset (byte_offset),
    .data_byte   (data_byte),
    .full        (full),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd         (front_cmd)
  );

  fpwc_fifo #(
    .DEPTH (CMD_DEPTH),
    .WIDTH ($bits(cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (front_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty),
    .count ()
  );

  fpwc_back #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .oq_count  (oq_count),
    .oq_push   (oq_push),
    .oq_data   (oq_wdata)
  );

  fpwc_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH ($bits(out_t))
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (),
    .pop   (pop),
    .rdata (oq_rdata),
    .empty (empty),
    .count (oq_count)
  );

  assign page_address = oq_rdata.page_address;
  assign word_index   = oq_rdata.word_index;
  assign word_data    = oq_rdata.word_data;
  assign last_word    = oq_rdata.last_word;
  assign bytes_stored = oq_rdata.bytes_stored;

endmodule

### design/fpwc_checker.sv
// Port-level checker of the page write combiner and its bind to the top level.
`include "flash_page_write_combiner_core_assert.svh"

module fpwc_checker
  import fpwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   full,
  input  logic                   empty,
  input  logic                   pop,
  input  logic [OUT_ADDR_W-1:0]  page_address,
  input  logic [WORD_IDX_W-1:0]  word_index,
  input  logic [DATA_W-1:0]      word_data,
  input  logic                   last_word,
  input  logic [COUNT_W-1:0]     bytes_stored
);

  logic [WORD_IDX_W-1:0]  exp_idx;
  logic [OUT_ADDR_W-1:0]  prev_page;
  logic [COUNT_W-1:0]     prev_count;

  // Tracks the word expected next within the page being read out.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (pop && !empty) begin
      exp_idx <= last_word ? '0 : word_index + WORD_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !empty) begin
      prev_page  <= page_address;
      prev_count <= bytes_stored;
    end
  end

  `FPWC_ASSERT_CLK(a_result_holds, !empty && !pop |=> !empty && $stable(word_data) && $stable(word_index), "result item changed while stalled")
  `FPWC_ASSERT_CLK(a_word_order, !empty |-> word_index == exp_idx, "page words out of order")
  `FPWC_ASSERT_CLK(a_page_steady, !empty && exp_idx != '0 |-> page_address == prev_page && bytes_stored == prev_count, "page address or count changed within a page")
  `FPWC_ASSERT_ALWAYS(a_reset_clear, rst |=> empty && !full, "queues not clear after reset")

endmodule

bind flash_page_write_combiner_core fpwc_checker u_fpwc_checker (.*);
